// ----- hw/rtl/srpr_pkg.sv -----
// shared types, constants and constant functions for the sar pixel ratio change block
`timescale 1ns / 1ps
`default_nettype none
package srpr_pkg;

    localparam int unsigned LOG_STEPS = 30;
    localparam int unsigned DIV_W     = 56;
    localparam int unsigned EXP_STEPS = 30;

    typedef enum logic [2:0] {
        CFG_INPUT_IS_DB          = 3'd0,
        CFG_OUTPUT_MODE          = 3'd1,
        CFG_NODATA_FIRST         = 3'd2,
        CFG_NODATA_SECOND        = 3'd3,
        CFG_NODATA_FIRST_ENABLE  = 3'd4,
        CFG_NODATA_SECOND_ENABLE = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] MODE_RATIO  = 2'd0;
    localparam logic [1:0] MODE_LOG_DB = 2'd1;

    // dB window for the ratio from dB samples
    localparam logic signed [32:0] DB_OVER  = 33'sd3014656;
    localparam logic signed [32:0] DB_UNDER = -33'sd3932160;
    localparam logic [31:0]        DB_DEN   = 32'd655360;
    localparam logic [35:0]        EXP_BIAS = 36'h8_0000_0000;
    localparam logic [31:0]        Q30_ONE  = 32'h4000_0000;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               bad;
    } t_log_side;

    typedef struct packed {
        logic neg;
        logic is_exp;
        logic bad;
    } t_div_side;

    typedef struct packed {
        logic        is_exp;
        logic        bad;
        logic [5:0]  ip;
        logic [31:0] value;
    } t_exp_side;

    typedef logic [EXP_STEPS-1:0][31:0] t_fac_arr;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = 64'd0;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bit_w > v) bit_w = bit_w >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_w != 64'd0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] f_log2_q30(input logic [63:0] x);
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] r;
        e = 64'd0;
        for (int i = 0; i < 30; i++) begin
            if ((x >> (e + 64'd1)) != 64'd0) e = e + 64'd1;
        end
        m = x << (64'd30 - e);
        r = e << 30;
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    // entry 0 is the factor for the top fraction bit
    function automatic t_fac_arr f_exp_factors();
        t_fac_arr    fac;
        logic [63:0] m;
        m = f_isqrt(64'd1 << 61);
        for (int j = 0; j < EXP_STEPS; j++) begin
            fac[j] = m[31:0];
            m      = f_isqrt(m << 30);
        end
        return fac;
    endfunction

    localparam logic [31:0] L10     = 32'(f_log2_q30(64'd10));
    localparam t_fac_arr    EXP_FAC = f_exp_factors();

endpackage
`default_nettype wire

// ----- hw/rtl/srpr_in_if.sv -----
// request channel carrying one pixel pair
`timescale 1ns / 1ps
`default_nettype none
interface srpr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_first;
    logic signed [31:0] sample_second;
    logic               finite_first;
    logic               finite_second;

    modport source (output valid, sample_first, sample_second, finite_first, finite_second,
                    input ready);
    modport sink (input valid, sample_first, sample_second, finite_first, finite_second,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/srpr_out_if.sv -----
// result channel carrying one change value
`timescale 1ns / 1ps
`default_nettype none
interface srpr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               result_invalid;

    modport source (output valid, result_value, result_invalid, input ready);
    modport sink (input valid, result_value, result_invalid, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/srpr_cfg_if.sv -----
// register write channel
`timescale 1ns / 1ps
`default_nettype none
interface srpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/srpr_log_cell.sv -----
// one squaring round of the log2 chain for both samples
`timescale 1ns / 1ps
`default_nettype none
module srpr_log_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire srpr_pkg::t_log_side   i_side,
    input  wire logic [30:0]           i_ma,
    input  wire logic [30:0]           i_mb,
    input  wire logic [34:0]           i_ra,
    input  wire logic [34:0]           i_rb,
    output logic                       o_valid,
    output srpr_pkg::t_log_side        o_side,
    output logic [30:0]                o_ma,
    output logic [30:0]                o_mb,
    output logic [34:0]                o_ra,
    output logic [34:0]                o_rb
);
    import srpr_pkg::*;

    logic        r_valid;
    t_log_side   r_side;
    logic [30:0] r_ma, r_mb;
    logic [34:0] r_ra, r_rb;
    logic [61:0] sq_a, sq_b;
    logic [31:0] sqs_a, sqs_b;
    logic [30:0] n_ma, n_mb;
    logic [34:0] n_ra, n_rb;

    assign sq_a  = 62'(i_ma) * 62'(i_ma);
    assign sq_b  = 62'(i_mb) * 62'(i_mb);
    assign sqs_a = sq_a[61:30];
    assign sqs_b = sq_b[61:30];

    // mantissa reaching two emits a one and is halved
    assign n_ma = sqs_a[31] ? sqs_a[31:1] : sqs_a[30:0];
    assign n_mb = sqs_b[31] ? sqs_b[31:1] : sqs_b[30:0];
    assign n_ra = {i_ra[33:0], sqs_a[31]};
    assign n_rb = {i_rb[33:0], sqs_b[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_ma   <= n_ma;
            r_mb   <= n_mb;
            r_ra   <= n_ra;
            r_rb   <= n_rb;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_ma    = r_ma;
    assign o_mb    = r_mb;
    assign o_ra    = r_ra;
    assign o_rb    = r_rb;
endmodule
`default_nettype wire

// ----- hw/rtl/srpr_div_cell.sv -----
// one restoring division step, one quotient bit
`timescale 1ns / 1ps
`default_nettype none
module srpr_div_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire srpr_pkg::t_div_side        i_side,
    input  wire logic [31:0]                i_rem,
    input  wire logic [srpr_pkg::DIV_W-1:0] i_w,
    input  wire logic [31:0]                i_den,
    output logic                            o_valid,
    output srpr_pkg::t_div_side             o_side,
    output logic [31:0]                     o_rem,
    output logic [srpr_pkg::DIV_W-1:0]      o_w,
    output logic [31:0]                     o_den
);
    import srpr_pkg::*;

    logic             r_valid;
    t_div_side        r_side;
    logic [31:0]      r_rem, r_den;
    logic [DIV_W-1:0] r_w;
    logic [32:0]      trial, diff;
    logic             ge;
    logic [31:0]      n_rem;
    logic [DIV_W-1:0] n_w;

    assign trial = {i_rem, i_w[DIV_W-1]};
    assign diff  = trial - {1'b0, i_den};
    assign ge    = trial >= {1'b0, i_den};
    assign n_rem = ge ? diff[31:0] : trial[31:0];
    // dividend bits leave at the top while quotient bits enter at the bottom
    assign n_w   = {i_w[DIV_W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_w    <= n_w;
            r_den  <= i_den;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_w     = r_w;
    assign o_den   = r_den;
endmodule
`default_nettype wire

// ----- hw/rtl/srpr_exp_cell.sv -----
// one fraction bit of the 2^f product chain
`timescale 1ns / 1ps
`default_nettype none
module srpr_exp_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire srpr_pkg::t_exp_side i_side,
    input  wire logic [31:0]         i_p,
    input  wire logic [29:0]         i_f,
    input  wire logic [31:0]         i_fac,
    output logic                     o_valid,
    output srpr_pkg::t_exp_side      o_side,
    output logic [31:0]              o_p,
    output logic [29:0]              o_f
);
    import srpr_pkg::*;

    logic        r_valid;
    t_exp_side   r_side;
    logic [31:0] r_p;
    logic [29:0] r_f;
    logic [63:0] prod, rnd;
    logic [31:0] n_p;
    logic [29:0] n_f;

    assign prod = 64'(i_p) * 64'(i_fac);
    assign rnd  = prod + (64'd1 << 29);
    assign n_p  = i_f[29] ? rnd[61:30] : i_p;
    assign n_f  = {i_f[28:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_p    <= n_p;
            r_f    <= n_f;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_p     = r_p;
    assign o_f     = r_f;
endmodule
`default_nettype wire

// ----- hw/rtl/sar_pixel_ratio_change_top.sv -----
// request path: front, normalise, log row, setup, divider row, split, exp row, buffer
// throughput: one request per cycle, set by the log, divide and exp cell rows
// all rows advance together; a two-entry result buffer stalls them only when full
// reset: synchronous, active low; clears valid bits, buffer count and config registers
// top level of the sar pixel ratio change block
`timescale 1ns / 1ps
`default_nettype none
module sar_pixel_ratio_change_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srpr_in_if.sink    i_in,
    srpr_out_if.source o_out,
    srpr_cfg_if.sink   i_cfg
);
    import srpr_pkg::*;

    // configuration
    logic        r_input_is_db;
    logic [1:0]  r_output_mode;
    logic [31:0] r_nodata_first, r_nodata_second;
    logic        r_nd1_en, r_nd2_en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_is_db   <= 1'b0;
            r_output_mode   <= MODE_RATIO;
            r_nodata_first  <= 32'd0;
            r_nodata_second <= 32'd0;
            r_nd1_en        <= 1'b0;
            r_nd2_en        <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_INPUT_IS_DB:          r_input_is_db   <= i_cfg.data[0];
                CFG_OUTPUT_MODE:          r_output_mode   <= i_cfg.data[1:0];
                CFG_NODATA_FIRST:         r_nodata_first  <= i_cfg.data;
                CFG_NODATA_SECOND:        r_nodata_second <= i_cfg.data;
                CFG_NODATA_FIRST_ENABLE:  r_nd1_en        <= i_cfg.data[0];
                CFG_NODATA_SECOND_ENABLE: r_nd2_en        <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // global advance, and the result buffer
    logic [1:0]  r_cnt;
    logic        r_wptr, r_rptr;
    logic [31:0] r_buf_value [2];
    logic        r_buf_bad   [2];
    logic        w_en, push, pop;

    assign w_en       = (r_cnt != 2'd2);
    assign i_in.ready = w_en;

    // front stage
    logic      r_s0_valid;
    t_log_side r_s0_side;
    t_log_side n_s0_side;

    always_comb begin
        n_s0_side.a   = i_in.sample_first;
        n_s0_side.b   = i_in.sample_second;
        n_s0_side.bad = !i_in.finite_first || !i_in.finite_second
                     || (r_nd1_en && (i_in.sample_first == r_nodata_first))
                     || (r_nd2_en && (i_in.sample_second == r_nodata_second));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side <= n_s0_side;
        end
    end

    // normalise both samples to [1,2) for the log rounds
    logic        r_s1_valid;
    t_log_side   r_s1_side;
    logic [30:0] r_s1_ma, r_s1_mb;
    logic [4:0]  r_s1_ea, r_s1_eb;
    logic [30:0] xa, xb;
    logic [4:0]  ea, eb;

    always_comb begin
        xa = (r_s0_side.a > 0) ? r_s0_side.a[30:0] : 31'd1;
        xb = (r_s0_side.b > 0) ? r_s0_side.b[30:0] : 31'd1;
        ea = 5'd0;
        eb = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (xa[i]) ea = 5'(i);
            if (xb[i]) eb = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side <= r_s0_side;
            r_s1_ma   <= xa << (5'd30 - ea);
            r_s1_mb   <= xb << (5'd30 - eb);
            r_s1_ea   <= ea;
            r_s1_eb   <= eb;
        end
    end

    // log2 row
    logic        lg_valid [LOG_STEPS+1];
    t_log_side   lg_side  [LOG_STEPS+1];
    logic [30:0] lg_ma    [LOG_STEPS+1];
    logic [30:0] lg_mb    [LOG_STEPS+1];
    logic [34:0] lg_ra    [LOG_STEPS+1];
    logic [34:0] lg_rb    [LOG_STEPS+1];

    assign lg_valid[0] = r_s1_valid;
    assign lg_side[0]  = r_s1_side;
    assign lg_ma[0]    = r_s1_ma;
    assign lg_mb[0]    = r_s1_mb;
    assign lg_ra[0]    = 35'(r_s1_ea);
    assign lg_rb[0]    = 35'(r_s1_eb);

    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        srpr_log_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (lg_valid[g]),
            .i_side  (lg_side[g]),
            .i_ma    (lg_ma[g]),
            .i_mb    (lg_mb[g]),
            .i_ra    (lg_ra[g]),
            .i_rb    (lg_rb[g]),
            .o_valid (lg_valid[g+1]),
            .o_side  (lg_side[g+1]),
            .o_ma    (lg_ma[g+1]),
            .o_mb    (lg_mb[g+1]),
            .o_ra    (lg_ra[g+1]),
            .o_rb    (lg_rb[g+1])
        );
    end

    // set up dividend magnitude, divisor and sign per mode
    t_log_side          lt;
    logic signed [32:0] d;
    logic [32:0]        abs_d;
    logic [31:0]        abs_a, abs_b;
    logic signed [35:0] ldiff;
    logic [34:0]        abs_ldiff;
    logic [53:0]        prod_db;
    logic [DIV_W-1:0]   p1_mag;
    logic [31:0]        p1_den;
    t_div_side          p1_side;

    assign lt        = lg_side[LOG_STEPS];
    assign d         = 33'(lt.a) - 33'(lt.b);
    assign abs_d     = d[32] ? 33'(-d) : 33'(d);
    assign abs_a     = lt.a[31] ? (~lt.a + 32'd1) : lt.a;
    assign abs_b     = lt.b[31] ? (~lt.b + 32'd1) : lt.b;
    assign ldiff     = $signed({1'b0, lg_ra[LOG_STEPS]}) - $signed({1'b0, lg_rb[LOG_STEPS]});
    assign abs_ldiff = ldiff[35] ? 35'(-ldiff) : 35'(ldiff);
    assign prod_db   = 54'(abs_d[21:0]) * 54'(L10);

    always_comb begin
        p1_mag         = '0;
        p1_den         = 32'd1;
        p1_side.neg    = 1'b0;
        p1_side.is_exp = 1'b0;
        p1_side.bad    = lt.bad;
        if (r_output_mode == MODE_RATIO) begin
            if (!r_input_is_db) begin
                if (lt.b == 0) p1_side.bad = 1'b1;
                p1_mag      = DIV_W'(abs_a) << 16;
                p1_den      = abs_b;
                p1_side.neg = lt.a[31] ^ lt.b[31];
            end else if (d >= DB_OVER) begin
                p1_side.bad = 1'b1;
            end else if (d > DB_UNDER) begin
                // exponent in q30, scaled back by the exp row
                p1_mag         = DIV_W'(prod_db);
                p1_den         = DB_DEN;
                p1_side.neg    = d[32];
                p1_side.is_exp = 1'b1;
            end
        end else if (r_input_is_db) begin
            p1_mag      = DIV_W'(abs_d);
            p1_side.neg = d[32] && (r_output_mode == MODE_LOG_DB);
        end else begin
            if (lt.a <= 0 || lt.b <= 0) p1_side.bad = 1'b1;
            // times ten and 2^16
            p1_mag      = (DIV_W'(abs_ldiff) << 19) + (DIV_W'(abs_ldiff) << 17);
            p1_den      = L10;
            p1_side.neg = ldiff[35] && (r_output_mode == MODE_LOG_DB);
        end
    end

    logic             r_p1_valid, r_p2_valid;
    t_div_side        r_p1_side, r_p2_side;
    logic [DIV_W-1:0] r_p1_mag, r_p2_num;
    logic [31:0]      r_p1_den, r_p2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= lg_valid[LOG_STEPS];
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_side <= p1_side;
            r_p1_mag  <= p1_mag;
            r_p1_den  <= p1_den;
            r_p2_side <= r_p1_side;
            // half the divisor added for round to nearest
            r_p2_num  <= r_p1_mag + DIV_W'(r_p1_den >> 1);
            r_p2_den  <= r_p1_den;
        end
    end

    // divider row
    logic             dv_valid [DIV_W+1];
    t_div_side        dv_side  [DIV_W+1];
    logic [31:0]      dv_rem   [DIV_W+1];
    logic [DIV_W-1:0] dv_w     [DIV_W+1];
    logic [31:0]      dv_den   [DIV_W+1];

    assign dv_valid[0] = r_p2_valid;
    assign dv_side[0]  = r_p2_side;
    assign dv_rem[0]   = 32'd0;
    assign dv_w[0]     = r_p2_num;
    assign dv_den[0]   = r_p2_den;

    for (genvar g = 0; g < DIV_W; g++) begin : g_div
        srpr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dv_valid[g]),
            .i_side  (dv_side[g]),
            .i_rem   (dv_rem[g]),
            .i_w     (dv_w[g]),
            .i_den   (dv_den[g]),
            .o_valid (dv_valid[g+1]),
            .o_side  (dv_side[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_w     (dv_w[g+1]),
            .o_den   (dv_den[g+1])
        );
    end

    // signed quotient: final value or exponent split
    logic [DIV_W-1:0] q;
    t_div_side        qs;
    logic             q_ovf;
    logic [31:0]      q_val;
    logic [35:0]      u;
    t_exp_side        x_side;

    assign q     = dv_w[DIV_W];
    assign qs    = dv_side[DIV_W];
    assign q_ovf = (q[DIV_W-1:32] != '0) || (q[31] && (!qs.neg || q[30:0] != 31'd0));
    assign q_val = qs.neg ? (~q[31:0] + 32'd1) : q[31:0];
    assign u     = qs.neg ? (EXP_BIAS - q[35:0]) : (EXP_BIAS + q[35:0]);

    always_comb begin
        x_side.is_exp = qs.is_exp;
        x_side.bad    = qs.bad || (!qs.is_exp && q_ovf);
        x_side.ip     = u[35:30];
        x_side.value  = q_val;
    end

    logic        r_x_valid;
    t_exp_side   r_x_side;
    logic [29:0] r_x_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (w_en) begin
            r_x_valid <= dv_valid[DIV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_side <= x_side;
            r_x_f    <= u[29:0];
        end
    end

    // 2^frac row
    logic        ex_valid [EXP_STEPS+1];
    t_exp_side   ex_side  [EXP_STEPS+1];
    logic [31:0] ex_p     [EXP_STEPS+1];
    logic [29:0] ex_f     [EXP_STEPS+1];

    assign ex_valid[0] = r_x_valid;
    assign ex_side[0]  = r_x_side;
    assign ex_p[0]     = Q30_ONE;
    assign ex_f[0]     = r_x_f;

    for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
        srpr_exp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (ex_valid[g]),
            .i_side  (ex_side[g]),
            .i_p     (ex_p[g]),
            .i_f     (ex_f[g]),
            .i_fac   (EXP_FAC[g]),
            .o_valid (ex_valid[g+1]),
            .o_side  (ex_side[g+1]),
            .o_p     (ex_p[g+1]),
            .o_f     (ex_f[g+1])
        );
    end

    // scale by the integer part and round to q16.16
    t_exp_side   es;
    logic [35:0] r36;
    logic [5:0]  sh_dn, sh_rd;
    logic        z_bad;
    logic [31:0] z_value;

    assign es    = ex_side[EXP_STEPS];
    assign sh_dn = 6'd46 - es.ip;
    assign sh_rd = 6'd45 - es.ip;

    always_comb begin
        if (es.ip >= 6'd46) begin
            r36 = 36'(ex_p[EXP_STEPS]) << (es.ip - 6'd46);
        end else begin
            r36 = (36'(ex_p[EXP_STEPS]) + (36'd1 << sh_rd)) >> sh_dn;
        end
        z_bad   = es.bad || (es.is_exp && (r36[35:31] != 5'd0));
        z_value = z_bad ? 32'd0 : (es.is_exp ? r36[31:0] : es.value);
    end

    assign push = w_en && ex_valid[EXP_STEPS];
    assign pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf_value[r_wptr] <= z_value;
            r_buf_bad[r_wptr]   <= z_bad;
        end
    end

    assign o_out.valid          = (r_cnt != 2'd0);
    assign o_out.result_value   = r_buf_value[r_rptr];
    assign o_out.result_invalid = r_buf_bad[r_rptr];
endmodule
`default_nettype wire

// ----- bench/sar_pixel_ratio_change_top_tb.sv -----
// self-checking bench for the sar pixel ratio change block with its own bit-exact predictor
`timescale 1ns / 1ps
`default_nettype none
module sar_pixel_ratio_change_top_tb;
    import srpr_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic               invalid;
    } t_change;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        bit          fa;
        bit          fb;
        bit          known;
        logic [31:0] value;
        bit          invalid;
    } t_row;

    typedef struct {
        bit          db;
        logic [1:0]  mode;
        logic [31:0] nd_first;
        logic [31:0] nd_second;
        bit          en_first;
        bit          en_second;
    } t_setting;

    localparam int N_PHASES  = 9;
    localparam int PHASE_LEN = 215;
    localparam int LATENCY   = 121;

    logic i_clk;
    logic i_rst_n;

    srpr_in_if  in_ch();
    srpr_out_if out_ch();
    srpr_cfg_if cfg_ch();

    sar_pixel_ratio_change_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // register copies used by the predictor
    bit          sh_db;
    logic [1:0]  sh_mode;
    logic [31:0] sh_nd_first;
    logic [31:0] sh_nd_second;
    bit          sh_en_first;
    bit          sh_en_second;

    t_change pending_change_q[$];
    int      err_cnt;
    int      checked_cnt;
    int      invalid_cnt;
    bit      row_known;
    t_change row_change;
    int      stall_pct;
    bit      hold_req;
    int      hold_cnt;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
        longint unsigned v, res, bitv;
        v    = v_in;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned log2_fix(input longint unsigned x);
        int unsigned     e;
        longint unsigned m, r;
        e = 0;
        while (e < 30 && (x >> (e + 1)) != 0) e++;
        m = x << (30 - e);
        r = longint'(e) << 30;
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    function automatic longint unsigned pow2_frac(input longint unsigned f);
        longint unsigned p, m;
        p = 64'd1 << 30;
        m = sqrt_floor(64'd1 << 61);
        for (int k = 29; k >= 0; k--) begin
            if ((f >> k) & 1) p = (p * m + (64'd1 << 29)) >> 30;
            m = sqrt_floor(m << 30);
        end
        return p;
    endfunction

    // nearest, ties away from zero
    function automatic longint div_round(input longint num, input longint den);
        longint unsigned mag, q;
        mag = num < 0 ? -num : num;
        q   = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_change change_of_pair(input logic [31:0] ra, input logic [31:0] rb,
                                               input bit fa, input bit fb);
        longint          a, b, v, d, t, num, den, diff, l10;
        longint unsigned u, p, r;
        int unsigned     ip;
        bit              bad;
        t_change         res;
        a   = longint'(signed'(ra));
        b   = longint'(signed'(rb));
        v   = 0;
        bad = 0;
        l10 = longint'(log2_fix(10));
        if (!fa || !fb || (sh_en_first && ra == sh_nd_first) ||
            (sh_en_second && rb == sh_nd_second)) begin
            bad = 1;
        end else if (sh_mode == MODE_RATIO) begin
            if (!sh_db) begin
                if (b == 0) begin
                    bad = 1;
                end else begin
                    num = a * 65536;
                    den = b;
                    if (den < 0) begin
                        num = -num;
                        den = -den;
                    end
                    v = div_round(num, den);
                end
            end else begin
                d = a - b;
                if (d >= 46 * 65536) begin
                    bad = 1;
                end else if (d > -60 * 65536) begin
                    t  = div_round(d * l10, 10 * 65536);
                    u  = t + (64'd32 << 30);
                    ip = u >> 30;
                    p  = pow2_frac(u & ((64'd1 << 30) - 1));
                    if (ip >= 46) r = p << (ip - 46);
                    else r = (p + (64'd1 << (45 - ip))) >> (46 - ip);
                    v = longint'(r);
                end
            end
        end else begin
            if (sh_db) begin
                v = a - b;
            end else if (a <= 0 || b <= 0) begin
                bad = 1;
            end else begin
                diff = longint'(log2_fix(a)) - longint'(log2_fix(b));
                v    = div_round(diff * 10 * 65536, l10);
            end
            if (sh_mode != MODE_LOG_DB && v < 0) v = -v;
        end
        if (!bad && (v > 64'sd2147483647 || v < -64'sd2147483648)) bad = 1;
        res.value   = bad ? 32'd0 : v[31:0];
        res.invalid = bad;
        return res;
    endfunction

    // request monitor: expectation taken at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (row_known) pending_change_q.push_back(row_change);
            else pending_change_q.push_back(change_of_pair(in_ch.sample_first,
                in_ch.sample_second, in_ch.finite_first, in_ch.finite_second));
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_change exp_c;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_change_q.size() == 0) begin
                $error("result_value: no result expected, got %0d", out_ch.result_value);
                err_cnt++;
            end else begin
                exp_c = pending_change_q.pop_front();
                checked_cnt++;
                if (exp_c.invalid) invalid_cnt++;
                if (out_ch.result_value !== exp_c.value) begin
                    $error("result_value: expected %0d, got %0d", exp_c.value,
                           out_ch.result_value);
                    err_cnt++;
                end
                if (out_ch.result_invalid !== exp_c.invalid) begin
                    $error("result_invalid: expected %0b, got %0b", exp_c.invalid,
                           out_ch.result_invalid);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stalls, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= 0;
        end else if (hold_req && hold_cnt == 0) begin
            hold_cnt     <= 400;
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt     <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_INPUT_IS_DB:          sh_db        = data[0];
            CFG_OUTPUT_MODE:          sh_mode      = data[1:0];
            CFG_NODATA_FIRST:         sh_nd_first  = data;
            CFG_NODATA_SECOND:        sh_nd_second = data;
            CFG_NODATA_FIRST_ENABLE:  sh_en_first  = data[0];
            CFG_NODATA_SECOND_ENABLE: sh_en_second = data[0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b,
                             input bit fa, input bit fb);
        in_ch.valid         <= 1'b1;
        in_ch.sample_first  <= a;
        in_ch.sample_second <= b;
        in_ch.finite_first  <= fa;
        in_ch.finite_second <= fb;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_change_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample(input bit db_in, input logic [31:0] nd);
        logic [31:0] edges[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return edges[$urandom_range(0, 4)];
            2: return nd;
            default: begin
                if (db_in) return $urandom_range(0, 100 * 65536) - 50 * 65536;
                return $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 30);
            end
        endcase
    endfunction

    initial begin
        t_row     rows[12];
        t_setting plan[N_PHASES];
        int       gap;
        int       burst;
        int       sent;
        rows[0]  = '{32'h0001_0000, 32'h0001_0000, 1, 1, 1, 32'h0001_0000, 0};
        rows[1]  = '{32'h0002_0000, 32'h0001_0000, 1, 1, 1, 32'h0002_0000, 0};
        rows[2]  = '{32'h0005_0000, 32'h0, 1, 1, 1, 32'h0, 1};
        rows[3]  = '{32'h0001_0000, 32'h0001_0000, 0, 1, 1, 32'h0, 1};
        rows[4]  = '{32'h0001_0000, 32'h0001_0000, 1, 0, 1, 32'h0, 1};
        rows[5]  = '{32'h7fff_ffff, 32'h1, 1, 1, 1, 32'h0, 1};
        rows[6]  = '{32'h8000_0000, 32'hffff_ffff, 1, 1, 1, 32'h0, 1};
        rows[7]  = '{32'h0, 32'h5, 1, 1, 1, 32'h0, 0};
        rows[8]  = '{32'h8000_0000, 32'h7fff_ffff, 1, 1, 0, 32'h0, 0};
        rows[9]  = '{32'h7fff_ffff, 32'h8000_0000, 1, 1, 0, 32'h0, 0};
        rows[10] = '{32'h0003_0000, 32'hfffe_0000, 1, 1, 0, 32'h0, 0};
        rows[11] = '{32'h1234_5678, 32'h0000_0007, 1, 1, 0, 32'h0, 0};
        plan[0] = '{0, 2'd0, 32'h0001_0000, 32'h0, 1, 1};
        plan[1] = '{1, 2'd0, 32'h0, 32'h0005_0000, 0, 1};
        plan[2] = '{0, 2'd1, 32'h8000_0000, 32'h7fff_ffff, 1, 1};
        plan[3] = '{1, 2'd1, 32'h0, 32'h0, 0, 0};
        plan[4] = '{0, 2'd2, 32'h7fff_ffff, 32'h8000_0000, 1, 0};
        plan[5] = '{1, 2'd2, 32'hfff6_0000, 32'h000a_0000, 1, 1};
        plan[6] = '{0, 2'd3, 32'h0, 32'h0001_0000, 0, 1};
        plan[7] = '{1, 2'd3, 32'h8000_0000, 32'h7fff_ffff, 1, 1};
        plan[8] = '{0, 2'd0, 32'h0, 32'h0, 0, 0};

        err_cnt = 0;
        checked_cnt = 0;
        invalid_cnt = 0;
        row_known = 0;
        row_change = '0;
        stall_pct = 0;
        hold_req = 0;
        sh_db = 0;
        sh_mode = 2'd0;
        sh_nd_first = 0;
        sh_nd_second = 0;
        sh_en_first = 0;
        sh_en_second = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample_first = '0;
        in_ch.sample_second = '0;
        in_ch.finite_first = 1'b0;
        in_ch.finite_second = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: linear ratio, no nodata
        stall_pct = 30;
        foreach (rows[i]) begin
            // updated with the request so the monitor sees the row being accepted
            row_known          <= rows[i].known;
            row_change.value   <= rows[i].value;
            row_change.invalid <= rows[i].invalid;
            send_pair(rows[i].a, rows[i].b, rows[i].fa, rows[i].fb);
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        row_known = 0;
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(CFG_INPUT_IS_DB, {31'd0, plan[ph].db});
            write_reg(CFG_OUTPUT_MODE, {30'd0, plan[ph].mode});
            write_reg(CFG_NODATA_FIRST, plan[ph].nd_first);
            write_reg(CFG_NODATA_SECOND, plan[ph].nd_second);
            write_reg(CFG_NODATA_FIRST_ENABLE, {31'd0, plan[ph].en_first});
            write_reg(CFG_NODATA_SECOND_ENABLE, {31'd0, plan[ph].en_second});
            stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
            if (ph == 3) hold_req = 1;
            sent = 0;
            while (sent < PHASE_LEN) begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < PHASE_LEN; k++) begin
                    send_pair(pick_sample(sh_db, sh_nd_first),
                              pick_sample(sh_db, sh_nd_second),
                              $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0);
                    sent++;
                    // keep asking until the receiver has started its hold-off
                    if (hold_cnt != 0) hold_req = 0;
                end
                if (ph == 5 && sent >= 100 && sent < 125) begin
                    in_ch.valid <= 1'b0;
                    while (pending_change_q.size() != 0) @(posedge i_clk);
                end
                gap = (ph % 3 == 0) ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("covered %0d results (%0d invalid) over %0d register settings,",
                 checked_cnt, invalid_cnt, N_PHASES + 1);
        $display("linear and dB input, all output modes, nodata and stall cases");
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
